// ===== rtl/core/hgrs_pkg.sv =====
// Package for the HTTP GET request scanner: result type, codes and
// constants, and the keyword character tables. No dependencies.
package hgrs_pkg;

  localparam int unsigned MAX_LINE      = 4096;
  localparam int unsigned LINE_CNT_W    = $clog2(MAX_LINE + 2);
  localparam int unsigned URI_MAX_CHARS = 1023;
  localparam int unsigned SHORT_CAP     = 15;
  localparam int unsigned CNT_W         = $clog2(URI_MAX_CHARS + 1);

  localparam logic [LINE_CNT_W-1:0] LINE_LIMIT = LINE_CNT_W'(MAX_LINE + 1);
  localparam logic [CNT_W-1:0]      URI_CAP    = CNT_W'(URI_MAX_CHARS);
  localparam logic [CNT_W-1:0]      SHORT_TCAP = CNT_W'(SHORT_CAP);

  localparam logic [1:0] TAG_NONE    = 2'd0;
  localparam logic [1:0] TAG_METHOD  = 2'd1;
  localparam logic [1:0] TAG_URI     = 2'd2;
  localparam logic [1:0] TAG_VERSION = 2'd3;

  localparam logic [1:0] VERDICT_OK          = 2'd0;
  localparam logic [1:0] VERDICT_BAD         = 2'd1;
  localparam logic [1:0] VERDICT_NOT_ALLOWED = 2'd2;

  localparam logic [2:0] METHOD_FULL = 3'd3;
  localparam logic [2:0] METHOD_FAIL = 3'd4;
  localparam logic [3:0] HDR_LAST    = 4'd10;
  localparam logic [3:0] VAL_DONE    = 4'd10;
  localparam logic [3:0] VAL_LAST    = 4'd9;
  localparam logic [3:0] VALUE_FAIL  = 4'd15;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] token_tag;
    logic       token_first;
    logic       request_done;
    logic [1:0] verdict;
    logic       persistent;
  } result_t;

  function automatic logic [7:0] get_char(input logic [1:0] pos);
    case (pos)
      2'd0:    get_char = "G";
      2'd1:    get_char = "E";
      2'd2:    get_char = "T";
      default: get_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] pos);
    case (pos)
      4'd0:    conn_char = "C";
      4'd1:    conn_char = "o";
      4'd2:    conn_char = "n";
      4'd3:    conn_char = "n";
      4'd4:    conn_char = "e";
      4'd5:    conn_char = "c";
      4'd6:    conn_char = "t";
      4'd7:    conn_char = "i";
      4'd8:    conn_char = "o";
      4'd9:    conn_char = "n";
      4'd10:   conn_char = ":";
      default: conn_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ka_char(input logic [3:0] pos);
    case (pos)
      4'd0:    ka_char = "k";
      4'd1:    ka_char = "e";
      4'd2:    ka_char = "e";
      4'd3:    ka_char = "p";
      4'd4:    ka_char = "-";
      4'd5:    ka_char = "a";
      4'd6:    ka_char = "l";
      4'd7:    ka_char = "i";
      4'd8:    ka_char = "v";
      4'd9:    ka_char = "e";
      default: ka_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== rtl/core/http_get_request_scanner.sv =====
// HTTP GET request scanner, one request byte in and one tagged result out per
// cycle while out_ready is high. Each byte goes through an input register, then
// the scanner logic, then an output register; with out_ready held high it takes
// one byte every cycle. The final byte's result carries the verdict and
// keep-alive flag, and the scanner then starts fresh for the next request.
// Depends on hgrs_pkg and hgrs_scan.
module http_get_request_scanner (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic [1:0] token_tag,
  output logic       token_first,
  output logic       request_done,
  output logic [1:0] verdict,
  output logic       persistent
);
  import hgrs_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       advance;
  result_t    scan_result;
  result_t    out_reg;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  hgrs_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (s1_data),
    .last_byte (s1_last),
    .result    (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_reg <= scan_result;
    end
  end

  assign byte_out     = out_reg.byte_out;
  assign token_tag    = out_reg.token_tag;
  assign token_first  = out_reg.token_first;
  assign request_done = out_reg.request_done;
  assign verdict      = out_reg.verdict;
  assign persistent   = out_reg.persistent;

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_data) && $stable(s1_last))
    else $error("input stage lost a request while stalled");

  a_block_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("request taken while both stages are full and stalled");

  a_verdict_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !request_done |-> verdict == VERDICT_OK && !persistent)
    else $error("verdict or keep-alive on a non-final byte");

  a_keep_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && persistent |-> verdict == VERDICT_OK)
    else $error("keep-alive without ok verdict");

  a_first_tagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_first |-> token_tag != TAG_NONE)
    else $error("token start on an untagged byte");

endmodule

// ===== rtl/core/hgrs_scan.sv =====
// Per-byte scanner: tokenizer, GET match, header and keep-alive matchers,
// and the verdict. Depends on hgrs_pkg.
module hgrs_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output hgrs_pkg::result_t result
);
  import hgrs_pkg::*;

  logic [LINE_CNT_W-1:0] line_length, line_length_next;
  logic                  line_ended, line_ended_next;
  logic                  previous_was_cr, previous_was_cr_next;
  logic                  text_ended_by_zero, text_ended_by_zero_next;
  logic [1:0]            token_index, token_index_next;
  logic                  inside_token, inside_token_next;
  logic [CNT_W-1:0]      token_char_count, token_char_count_next;
  logic [2:0]            method_match, method_match_next;
  logic [3:0]            header_match_position, header_match_position_next;
  logic                  header_found, header_found_next;
  logic [3:0]            value_match_position, value_match_position_next;
  logic                  value_matched, value_matched_next;

  logic             is_ws;
  logic             start;
  logic [CNT_W-1:0] cap;
  logic [7:0]       lc;
  logic [1:0]       tag;
  logic             first;
  logic [1:0]       verdict;

  assign is_ws = (data_byte == CH_SP) || (data_byte >= CH_TAB && data_byte <= CH_CR);
  assign lc    = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
  assign cap   = (token_index == TAG_URI) ? URI_CAP : SHORT_TCAP;

  always_comb begin
    line_length_next           = line_length;
    line_ended_next            = line_ended;
    previous_was_cr_next       = previous_was_cr;
    text_ended_by_zero_next    = text_ended_by_zero || (data_byte == 8'h00);
    token_index_next           = token_index;
    inside_token_next          = inside_token;
    token_char_count_next      = token_char_count;
    method_match_next          = method_match;
    header_match_position_next = header_match_position;
    header_found_next          = header_found;
    value_match_position_next  = value_match_position;
    value_matched_next         = value_matched;
    start                      = 1'b0;
    tag                        = TAG_NONE;
    first                      = 1'b0;
    verdict                    = VERDICT_OK;

    if (!text_ended_by_zero_next) begin
      if (!header_found) begin
        if (data_byte == conn_char(header_match_position)) begin
          header_match_position_next = header_match_position + 4'd1;
          if (header_match_position == HDR_LAST) header_found_next = 1'b1;
        end else begin
          header_match_position_next = (data_byte == "C") ? 4'd1 : 4'd0;
        end
      end else if (value_match_position < VAL_DONE) begin
        if (!(value_match_position == 4'd0 && (data_byte == CH_SP || data_byte == CH_TAB)))
        begin
          if (lc == ka_char(value_match_position)) begin
            value_match_position_next = value_match_position + 4'd1;
            if (value_match_position == VAL_LAST) value_matched_next = 1'b1;
          end else begin
            value_match_position_next = VALUE_FAIL;
          end
        end
      end

      if (!line_ended) begin
        if (data_byte == CH_LF && previous_was_cr) begin
          line_ended_next = 1'b1;
        end else begin
          if (line_length < LINE_LIMIT) line_length_next = line_length + 1'b1;
          if (is_ws) begin
            inside_token_next = 1'b0;
          end else begin
            start = !inside_token || (token_index != 2'd0 && token_char_count >= cap);
            if (start) begin
              if (token_index < TAG_VERSION) begin
                token_index_next      = token_index + 2'd1;
                token_char_count_next = '0;
                inside_token_next     = 1'b1;
                first                 = 1'b1;
              end else begin
                inside_token_next = 1'b0;
              end
            end
            if (inside_token_next && token_index_next != TAG_NONE) begin
              tag = token_index_next;
              if (token_index_next == TAG_METHOD && method_match != METHOD_FAIL) begin
                if (token_char_count_next < CNT_W'(3) &&
                    data_byte == get_char(token_char_count_next[1:0]))
                  method_match_next = 3'(token_char_count_next) + 3'd1;
                else
                  method_match_next = METHOD_FAIL;
              end
              token_char_count_next = token_char_count_next + 1'b1;
            end
          end
        end
      end
      previous_was_cr_next = (data_byte == CH_CR);
    end

    if (last_byte) begin
      if (!line_ended_next || line_length_next >= LINE_LIMIT || token_index_next < TAG_VERSION)
        verdict = VERDICT_BAD;
      else if (method_match_next != METHOD_FULL)
        verdict = VERDICT_NOT_ALLOWED;
      else
        verdict = VERDICT_OK;
    end
  end

  always_comb begin
    result.byte_out     = data_byte;
    result.token_tag    = tag;
    result.token_first  = first;
    result.request_done = last_byte;
    result.verdict      = verdict;
    result.persistent   = last_byte && verdict == VERDICT_OK && value_matched_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      line_length           <= '0;
      line_ended            <= 1'b0;
      previous_was_cr       <= 1'b0;
      text_ended_by_zero    <= 1'b0;
      token_index           <= '0;
      inside_token          <= 1'b0;
      token_char_count      <= '0;
      method_match          <= '0;
      header_match_position <= '0;
      header_found          <= 1'b0;
      value_match_position  <= '0;
      value_matched         <= 1'b0;
    end else if (advance) begin
      line_length           <= line_length_next;
      line_ended            <= line_ended_next;
      previous_was_cr       <= previous_was_cr_next;
      text_ended_by_zero    <= text_ended_by_zero_next;
      token_index           <= token_index_next;
      inside_token          <= inside_token_next;
      token_char_count      <= token_char_count_next;
      method_match          <= method_match_next;
      header_match_position <= header_match_position_next;
      header_found          <= header_found_next;
      value_match_position  <= value_match_position_next;
      value_matched         <= value_matched_next;
    end
  end

endmodule
